// ===== src/gsat_pkg.sv =====
// Package: shared types and constants for guest segment address translation.
`timescale 1ns / 1ps
`default_nettype none
package gsat_pkg;

  // Payload widths
  localparam int VADDR_W = 64;
  localparam int PRIV_W  = 2;
  localparam int EXC_W   = 2;
  localparam int WORD_W  = 32;
  localparam int HALF_W  = 16;
  localparam int CFG_IDX_W = 2;

  // Default physical address width of the result
  localparam int ADDR_WIDTH_DEFAULT = 64;

  // xkphys keeps this many low address bits
  localparam int XKPHYS_KEEP = 59;

  typedef logic [VADDR_W-1:0] vaddr_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [HALF_W-1:0]  half_t;
  typedef logic [PRIV_W-1:0]  priv_t;
  typedef logic [EXC_W-1:0]   exc_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEG_CTL_HIGH   = 2'd0,
    REG_SEG_CTL_KERNEL = 2'd1,
    REG_SEG_CTL_USER   = 2'd2,
    REG_WIDE_MODE      = 2'd3
  } cfg_reg_t;

  // Reset values of the segment control words
  localparam word_t SEG_HIGH_RESET   = 32'h0020_0010;
  localparam word_t SEG_KERNEL_RESET = 32'h0003_0002;
  localparam word_t SEG_USER_RESET   = 32'h0433_0033;
  localparam logic  WIDE_MODE_RESET  = 1'b1;

  // Access mode codes (segment half bits 6:4)
  typedef enum logic [2:0] {
    AM_UK    = 3'd0,
    AM_MK    = 3'd1,
    AM_MSK   = 3'd2,
    AM_MUSK  = 3'd3,
    AM_MUSUK = 3'd4,
    AM_USK   = 3'd5,
    AM_RSVD  = 3'd6,
    AM_UUSK  = 3'd7
  } access_mode_t;

  // xkphys region code in address bits 63:62
  localparam logic [1:0] XKPHYS_REGION = 2'b10;

  // Current configuration as seen by the translation logic
  typedef struct packed {
    word_t seg_ctl_high;
    word_t seg_ctl_kernel;
    word_t seg_ctl_user;
    logic  wide_mode;
  } cfg_t;

endpackage
`default_nettype wire

// ===== src/gsat_if.sv =====
// Interfaces: request and response channels of the address translator.
`timescale 1ns / 1ps
`default_nettype none
interface gsat_req_if;
  logic             valid;
  logic             ready;
  gsat_pkg::vaddr_t guest_vaddr;
  gsat_pkg::priv_t  priv_mode;
  gsat_pkg::exc_t   exception_flags;

  modport source (output valid, output guest_vaddr, output priv_mode,
                  output exception_flags, input ready);
  modport sink   (input valid, input guest_vaddr, input priv_mode,
                  input exception_flags, output ready);
endinterface

interface gsat_rsp_if;
  logic             valid;
  logic             ready;
  logic             mapped;
  gsat_pkg::vaddr_t out_addr;

  modport source (output valid, output mapped, output out_addr, input ready);
  modport sink   (input valid, input mapped, input out_addr, output ready);
endinterface
`default_nettype wire

// ===== src/gsat_cfg_regs.sv =====
// Configuration register file: segment control words and address mode.
`timescale 1ns / 1ps
`default_nettype none
module gsat_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [gsat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire gsat_pkg::word_t                cfg_data,
  output gsat_pkg::cfg_t                      cfg
);

  gsat_pkg::cfg_t regs;

  // Register writes, decoded by index
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.seg_ctl_high   <= gsat_pkg::SEG_HIGH_RESET;
      regs.seg_ctl_kernel <= gsat_pkg::SEG_KERNEL_RESET;
      regs.seg_ctl_user   <= gsat_pkg::SEG_USER_RESET;
      regs.wide_mode      <= gsat_pkg::WIDE_MODE_RESET;
    end else if (cfg_we) begin
      case (gsat_pkg::cfg_reg_t'(cfg_index))
        gsat_pkg::REG_SEG_CTL_HIGH:   regs.seg_ctl_high   <= cfg_data;
        gsat_pkg::REG_SEG_CTL_KERNEL: regs.seg_ctl_kernel <= cfg_data;
        gsat_pkg::REG_SEG_CTL_USER:   regs.seg_ctl_user   <= cfg_data;
        gsat_pkg::REG_WIDE_MODE:      regs.wide_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule
`default_nettype wire

// ===== src/gsat_seg_xlate.sv =====
// Combinational segment lookup and address translation for one request.
`timescale 1ns / 1ps
`default_nettype none
module gsat_seg_xlate #(
  parameter int ADDR_WIDTH = gsat_pkg::ADDR_WIDTH_DEFAULT
) (
  input  wire gsat_pkg::cfg_t    cfg,
  input  wire gsat_pkg::vaddr_t  vaddr,
  input  wire gsat_pkg::priv_t   priv_mode,
  input  wire gsat_pkg::exc_t    exception_flags,
  output logic                   mapped,
  output logic [ADDR_WIDTH-1:0]  addr
);

  gsat_pkg::vaddr_t      va;
  gsat_pkg::word_t       word;
  gsat_pkg::half_t       half;
  gsat_pkg::access_mode_t mode;
  logic                  seg_mapped;
  logic                  kernel_level;
  gsat_pkg::vaddr_t      seg_addr;
  logic                  compat;
  gsat_pkg::vaddr_t      full;

  // Narrow mode looks only at the low 32 bits
  assign va = cfg.wide_mode ? vaddr : gsat_pkg::vaddr_t'(vaddr[31:0]);

  // Pick the control half for the segment in bits 31:29
  always_comb begin
    if (va[31]) begin
      word = va[30] ? cfg.seg_ctl_high : cfg.seg_ctl_kernel;
      half = va[29] ? word[15:0] : word[31:16];
    end else begin
      word = cfg.seg_ctl_user;
      half = va[30] ? word[15:0] : word[31:16];
    end
  end

  assign mode         = gsat_pkg::access_mode_t'(half[6:4]);
  assign kernel_level = (priv_mode == '0) || (exception_flags != '0);

  // Access mode decode
  always_comb begin
    case (mode)
      gsat_pkg::AM_UK, gsat_pkg::AM_USK, gsat_pkg::AM_UUSK: seg_mapped = 1'b0;
      gsat_pkg::AM_MUSUK: seg_mapped = !kernel_level;
      default: seg_mapped = 1'b1;
    endcase
  end

  // Segment result: base bits from the half replace the upper address bits
  always_comb begin
    if (seg_mapped) begin
      seg_addr = va;
    end else if (va[31]) begin
      seg_addr = gsat_pkg::vaddr_t'({half[15:9], va[28:0]});
    end else begin
      seg_addr = gsat_pkg::vaddr_t'({half[15:10], va[29:0]});
    end
  end

  // Sign-extended compatibility range
  assign compat = (va[63:31] == '0) || (va[63:31] == '1);

  // Region select
  always_comb begin
    if (!cfg.wide_mode) begin
      mapped = seg_mapped;
      full   = gsat_pkg::vaddr_t'(seg_addr[31:0]);
    end else if (compat) begin
      mapped = seg_mapped;
      full   = seg_addr;
    end else if (va[63:62] == gsat_pkg::XKPHYS_REGION) begin
      mapped = 1'b0;
      full   = gsat_pkg::vaddr_t'(va[gsat_pkg::XKPHYS_KEEP-1:0]);
    end else begin
      mapped = 1'b1;
      full   = va;
    end
  end

  assign addr = full[ADDR_WIDTH-1:0];

endmodule
`default_nettype wire

// ===== src/guest_segment_address_translate.sv =====
// Top level: guest segment address translator with request and result registers.
`timescale 1ns / 1ps
`default_nettype none
// Translates one guest virtual address per cycle, while the result side keeps
// taking results, into a mapped flag and, for unmapped addresses, a physical
// address. Each request is captured in an input register, translated by one pass
// of segment lookup logic and held in a result register, and a new request is
// accepted every cycle while the result side keeps taking results. The user must
// write the segment control words and the 64-bit mode bit through the configuration
// port only while no request is in flight; the block itself does not enforce it.
// out_addr carries the low ADDR_WIDTH bits of the result, zero above.
module guest_segment_address_translate #(
  parameter int ADDR_WIDTH = gsat_pkg::ADDR_WIDTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [gsat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire gsat_pkg::word_t                cfg_data,
  gsat_req_if.sink                            req,
  gsat_rsp_if.source                          rsp
);

  gsat_pkg::cfg_t cfg;

  // Input stage
  logic             s1_valid;
  gsat_pkg::vaddr_t s1_vaddr;
  gsat_pkg::priv_t  s1_priv;
  gsat_pkg::exc_t   s1_exc;

  // Result stage
  logic                  out_valid;
  logic                  out_mapped;
  logic [ADDR_WIDTH-1:0] out_addr;

  logic                  xl_mapped;
  logic [ADDR_WIDTH-1:0] xl_addr;
  logic                  out_load;
  logic                  s1_load;

  gsat_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gsat_seg_xlate #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_xlate (
    .cfg             (cfg),
    .vaddr           (s1_vaddr),
    .priv_mode       (s1_priv),
    .exception_flags (s1_exc),
    .mapped          (xl_mapped),
    .addr            (xl_addr)
  );

  // Pipeline flow control
  assign out_load  = !out_valid || rsp.ready;
  assign s1_load   = !s1_valid || out_load;
  assign req.ready = s1_load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= req.valid;
    end
    if (s1_load && req.valid) begin
      s1_vaddr <= req.guest_vaddr;
      s1_priv  <= req.priv_mode;
      s1_exc   <= req.exception_flags;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
    if (out_load && s1_valid) begin
      out_mapped <= xl_mapped;
      out_addr   <= xl_addr;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.mapped   = out_mapped;
  assign rsp.out_addr = gsat_pkg::vaddr_t'(out_addr);

endmodule
`default_nettype wire

// ===== tb/tb_guest_segment_address_translate.sv =====
// Testbench: directed and random requests through the guest segment address translator.
`timescale 1ns / 1ps
`default_nettype none
module tb_guest_segment_address_translate;
  import gsat_pkg::*;

  localparam int     ADDR_W      = ADDR_WIDTH_DEFAULT;
  localparam vaddr_t ADDR_MASK   = {VADDR_W{1'b1}} >> (VADDR_W - ADDR_W);
  localparam vaddr_t XKPHYS_MASK = (64'd1 << XKPHYS_KEEP) - 64'd1;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     RAND_PHASES = 6;
  localparam int     ITEMS_PER_LOOP = 56;
  localparam int     LONG_HOLD   = 300;

  // One translation outcome
  typedef struct {
    logic   mapped;
    vaddr_t addr;
  } xlat_t;

  // Keeps a copy of the configuration, predicts each request and checks results
  class xlat_checker;
    word_t seg_high;
    word_t seg_kernel;
    word_t seg_user;
    logic  wide;
    xlat_t expected_q[$];
    int    errors;

    function new();
      seg_high   = SEG_HIGH_RESET;
      seg_kernel = SEG_KERNEL_RESET;
      seg_user   = SEG_USER_RESET;
      wide       = WIDE_MODE_RESET;
      errors     = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, word_t data);
      case (idx)
        REG_SEG_CTL_HIGH:   seg_high   = data;
        REG_SEG_CTL_KERNEL: seg_kernel = data;
        REG_SEG_CTL_USER:   seg_user   = data;
        REG_WIDE_MODE:      wide       = data[0];
        default: ;
      endcase
    endfunction

    // Segment lookup on the low 32 bits of the address
    function xlat_t segment_lookup(vaddr_t a, priv_t p, exc_t e);
      word_t        w;
      half_t        h;
      access_mode_t m;
      xlat_t        r;
      if (a[31]) begin
        w = a[30] ? seg_high : seg_kernel;
        h = a[29] ? w[15:0] : w[31:16];
      end else begin
        w = seg_user;
        h = a[30] ? w[15:0] : w[31:16];
      end
      m = access_mode_t'(h[6:4]);
      case (m)
        AM_UK, AM_USK, AM_UUSK: r.mapped = 1'b0;
        AM_MUSUK:               r.mapped = (p != '0) && (e == '0);
        default:                r.mapped = 1'b1;
      endcase
      r.addr = a;
      // unmapped: base bits from the half, sign extension dropped
      if (!r.mapped) begin
        if (a[31]) r.addr = {28'd0, h[15:9], a[28:0]};
        else       r.addr = {28'd0, h[15:10], a[29:0]};
      end
      return r;
    endfunction

    function xlat_t translate(vaddr_t a, priv_t p, exc_t e);
      xlat_t r;
      if (wide) begin
        if (a < 64'h0000_0000_8000_0000 || a >= 64'hffff_ffff_8000_0000) begin
          r = segment_lookup(a, p, e);
        end else if (a[63:62] == XKPHYS_REGION) begin
          r.mapped = 1'b0;
          r.addr   = a & XKPHYS_MASK;
        end else begin
          r.mapped = 1'b1;
          r.addr   = a;
        end
      end else begin
        r = segment_lookup({32'd0, a[31:0]}, p, e);
        r.addr[63:32] = '0;
      end
      r.addr &= ADDR_MASK;
      return r;
    endfunction

    function void note_request(vaddr_t a, priv_t p, exc_t e);
      expected_q.push_back(translate(a, p, e));
    endfunction

    function void check_result(logic mapped, vaddr_t addr);
      xlat_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result mapped=%0b addr=%h", $time, mapped, addr);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (mapped !== exp_r.mapped) begin
        $display("%0t: mapped expected %0b actual %0b", $time, exp_r.mapped, mapped);
        errors++;
      end
      if (addr !== exp_r.addr) begin
        $display("%0t: out_addr expected %h actual %h", $time, exp_r.addr, addr);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic  clk;
  logic  rst;
  logic  cfg_we;
  logic  [CFG_IDX_W-1:0] cfg_index;
  word_t cfg_data;

  gsat_req_if req_ch ();
  gsat_rsp_if rsp_ch ();

  guest_segment_address_translate dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  xlat_checker xlat = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL guest_segment_address_translate");
    $finish;
  end

  // Result side: check accepted results, stall at random or for a long hold
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready)
        xlat.check_result(rsp_ch.mapped, rsp_ch.out_addr);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one request, idling first at random, and wait for acceptance
  task automatic send_req(input vaddr_t a, input priv_t p, input exc_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.guest_vaddr     <= a;
    req_ch.priv_mode       <= p;
    req_ch.exception_flags <= e;
    do @(posedge clk); while (!req_ch.ready);
    xlat.note_request(a, p, e);
  endtask

  // Stop offering and wait until every pending request has its result
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (xlat.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers; block must be idle
  task automatic apply_config(input word_t h, input word_t k, input word_t u, input logic w);
    cfg_reg_t idx[4];
    word_t    val[4];
    idx = '{REG_SEG_CTL_HIGH, REG_SEG_CTL_KERNEL, REG_SEG_CTL_USER, REG_WIDE_MODE};
    val = '{h, k, u, {31'd0, w}};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      xlat.set_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Address mix weighted toward the compatibility range and xkphys
  function automatic vaddr_t rand_vaddr();
    logic [31:0] hi;
    logic [31:0] lo;
    vaddr_t      edges[8];
    hi = $urandom();
    lo = $urandom();
    edges = '{64'h0000_0000_7fff_ffff, 64'h0000_0000_8000_0000,
              64'hffff_ffff_7fff_ffff, 64'hffff_ffff_8000_0000,
              64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
              64'hbfff_ffff_ffff_ffff, 64'hc000_0000_0000_0000};
    case ($urandom_range(9))
      0, 1:    return {32'd0, 1'b0, lo[30:0]};
      2, 3:    return {32'hffff_ffff, 1'b1, lo[30:0]};
      4, 5:    return {2'b10, hi[29:0], lo};
      6:       return edges[$urandom_range(7)];
      default: return {hi, lo};
    endcase
  endfunction

  // Stimulus
  initial begin
    vaddr_t dir_addr[12];
    vaddr_t dir_narrow[9];
    priv_t  dir_priv[9];
    exc_t   dir_exc[9];
    int     idle_send[4];
    int     idle_recv[4];
    word_t  wh;
    word_t  wk;
    word_t  wu;
    logic   ww;

    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_index              <= REG_SEG_CTL_HIGH;
    cfg_data               <= '0;
    req_ch.valid           <= 1'b0;
    req_ch.guest_vaddr     <= '0;
    req_ch.priv_mode       <= '0;
    req_ch.exception_flags <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration, 64-bit mode: segment edges, xkphys, mapped 64-bit space
    dir_addr = '{64'h0000_0000_0000_0000, 64'h0000_0000_7fff_ffff,
                 64'hffff_ffff_8000_0000, 64'hffff_ffff_a000_0000,
                 64'hffff_ffff_c000_0000, 64'hffff_ffff_ffff_ffff,
                 64'h0000_0000_8000_0000, 64'hffff_ffff_7fff_ffff,
                 64'h8000_0000_0000_0000, 64'hbfff_ffff_ffff_ffff,
                 64'h4000_0000_0000_0000, 64'h0000_0000_6000_0000};
    foreach (dir_addr[i])
      send_req(dir_addr[i], priv_t'(i % 4), exc_t'(i / 4));
    drain();

    // MUSUK mode at every privilege, unmapped modes with top base bits, 32-bit mode
    apply_config(32'hfc50_fc00, 32'hfe00_fe70, 32'h0040_0040, 1'b0);
    dir_narrow = '{64'h0000_0000_0000_0000, 64'h0000_0000_4000_0000,
                   64'h0000_0000_2000_0000, 64'h0000_0000_6000_0000,
                   64'h0000_0000_1234_5678, 64'hdead_beef_9fff_ffff,
                   64'ha5a5_a5a5_bfff_ffff, 64'hffff_ffff_dfff_ffff,
                   64'h0000_0000_ffff_ffff};
    dir_priv = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd1, 2'd0, 2'd2, 2'd3};
    dir_exc  = '{2'd0, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd0, 2'd1, 2'd0};
    foreach (dir_narrow[i])
      send_req(dir_narrow[i], dir_priv[i], dir_exc[i]);
    drain();

    // Random part: one configuration per phase, every idle pattern in each
    idle_send = '{0, 62, 0, 33};
    idle_recv = '{0, 0, 62, 33};
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wh = $urandom();
      wk = $urandom();
      wu = $urandom();
      ww = $urandom_range(1);
      case (ph)
        0: begin wh = '0; wk = '0; wu = '0; ww = 1'b0; end
        1: begin wh = '1; wk = '1; wu = '1; ww = 1'b1; end
        2: ww = 1'b0;
        3: ww = 1'b1;
        default: ;
      endcase
      apply_config(wh, wk, wu, ww);

      // Long result-side hold while requests keep coming, filling the block
      if (ph == 1) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = LONG_HOLD;
        repeat (30)
          send_req(rand_vaddr(), priv_t'($urandom_range(3)), exc_t'($urandom_range(3)));
      end

      for (int ip = 0; ip < 4; ip++) begin
        send_idle_pct  = idle_send[ip];
        recv_stall_pct = idle_recv[ip];
        repeat (ITEMS_PER_LOOP)
          send_req(rand_vaddr(), priv_t'($urandom_range(3)), exc_t'($urandom_range(3)));
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (xlat.errors == 0 && xlat.pending() == 0) begin
      $display("PASS guest_segment_address_translate");
    end else begin
      $display("FAIL guest_segment_address_translate");
    end
    $finish;
  end

endmodule
`default_nettype wire
